### rtl/core/wdsc_pkg.sv
// Package: shared types, constants and calendar helpers for the workday counter.
package wdsc_pkg;

  localparam int unsigned BaseYear = 2000;
  localparam int unsigned YearW    = 12;
  localparam int unsigned CountW   = 20;
  localparam int unsigned DayNumW  = 21;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_WEEK,
    ST_SUM,
    ST_HOLI,
    ST_DONE
  } wdsc_state_t;

  typedef struct packed {
    logic load;
    logic calc_days;
    logic calc_week;
    logic calc_sum;
    logic step_year;
    logic out_valid;
  } wdsc_cmd_t;

  typedef struct packed {
    logic last_year;
    logic out_taken;
  } wdsc_sts_t;

  // Year times 2^19/100: bits [24:19] hold y/100, and the low 19 bits stay
  // below 5243 exactly when y is a multiple of 100 (any 12-bit year).
  function automatic logic [24:0] scale100(input logic [YearW-1:0] y);
    begin
      scale100 = 25'(y) * 25'(5243);
    end
  endfunction

  // Leap year test on a year value.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [24:0] p;
    logic        c100;
    logic        c400;
    begin
      p    = scale100(y);
      c100 = (p[18:0] < 19'd5243);
      c400 = c100 && (p[20:19] == 2'd0);
      is_leap = ((y[1:0] == 2'd0) && !c100) || c400;
    end
  endfunction

  // Remainder by 7: fold octal digits, since 8 leaves 1.
  function automatic logic [2:0] mod7(input logic [DayNumW-1:0] n);
    logic [5:0] s;
    logic [3:0] t;
    logic [3:0] v;
    begin
      s = '0;
      for (int i = 0; i < DayNumW / 3; i++) s = s + 6'(n[3*i +: 3]);
      t = 4'(s[5:3]) + 4'(s[2:0]);
      v = 4'(t[3]) + 4'(t[2:0]);
      mod7 = (v >= 4'd7) ? 3'(v - 4'd7) : v[2:0];
    end
  endfunction

  // Quotient by 7 through a reciprocal multiply; exact for any 21-bit value.
  function automatic logic [CountW-1:0] div7(input logic [DayNumW-1:0] n);
    logic [42:0] p;
    begin
      p    = 43'(n) * 43'(2396746);
      div7 = CountW'(p[42:24]);
    end
  endfunction

  // Days before the start of month m (1..12) in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    begin
      unique case (m)
        4'd1:    month_start = 9'd0;
        4'd2:    month_start = 9'd31;
        4'd3:    month_start = 9'd59;
        4'd4:    month_start = 9'd90;
        4'd5:    month_start = 9'd120;
        4'd6:    month_start = 9'd151;
        4'd7:    month_start = 9'd181;
        4'd8:    month_start = 9'd212;
        4'd9:    month_start = 9'd243;
        4'd10:   month_start = 9'd273;
        4'd11:   month_start = 9'd304;
        4'd12:   month_start = 9'd334;
        default: month_start = 9'd0;
      endcase
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    begin
      unique case (m)
        4'd2:                       month_len = lp ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
        default:                    month_len = 5'd31;
      endcase
    end
  endfunction

  function automatic logic is_holiday(input logic [3:0] m, input logic [4:0] d);
    begin
      is_holiday = (m == 4'd1 && d == 5'd1) || (m == 4'd5 && d == 5'd1) ||
                   (m == 4'd5 && d == 5'd8) || (m == 4'd7 && d == 5'd5) ||
                   (m == 4'd7 && d == 5'd6) || (m == 4'd9 && d == 5'd28) ||
                   (m == 4'd10 && d == 5'd28) || (m == 4'd11 && d == 5'd17) ||
                   (m == 4'd12 && d >= 5'd24 && d <= 5'd26);
    end
  endfunction

  // Day of year (0-based) of a holiday slot, with leap correction.
  function automatic logic [8:0] holiday_doy(input logic [3:0] idx, input logic lp);
    logic [8:0] base;
    begin
      unique case (idx)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd120;
        4'd2:    base = 9'd127;
        4'd3:    base = 9'd185;
        4'd4:    base = 9'd186;
        4'd5:    base = 9'd270;
        4'd6:    base = 9'd300;
        4'd7:    base = 9'd320;
        4'd8:    base = 9'd357;
        4'd9:    base = 9'd358;
        default: base = 9'd359;
      endcase
      holiday_doy = (idx != 4'd0 && lp) ? base + 9'd1 : base;
    end
  endfunction

  // Day of year of a holiday slot taken modulo 7, with leap correction.
  function automatic logic [2:0] holiday_dow(input logic [3:0] idx, input logic lp);
    logic [2:0] base;
    begin
      unique case (idx)
        4'd0:    base = 3'd0;
        4'd1:    base = 3'd1;
        4'd2:    base = 3'd1;
        4'd3:    base = 3'd3;
        4'd4:    base = 3'd4;
        4'd5:    base = 3'd4;
        4'd6:    base = 3'd6;
        4'd7:    base = 3'd5;
        4'd8:    base = 3'd0;
        4'd9:    base = 3'd1;
        default: base = 3'd2;
      endcase
      if (idx != 4'd0 && lp) holiday_dow = (base == 3'd6) ? 3'd0 : base + 3'd1;
      else                   holiday_dow = base;
    end
  endfunction

endpackage

### rtl/core/wdsc_if.sv
// Interfaces: valid/ready channels for requests and results.
interface wdsc_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] first_year;
  logic [3:0]  first_month;
  logic [4:0]  first_day;
  logic [11:0] second_year;
  logic [3:0]  second_month;
  logic [4:0]  second_day;
  modport source (output valid, mode, first_year, first_month, first_day,
                  second_year, second_month, second_day, input ready);
  modport sink (input valid, mode, first_year, first_month, first_day,
                second_year, second_month, second_day, output ready);
endinterface

interface wdsc_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic        is_work_day;
  logic [19:0] total_days;
  logic [19:0] work_days;
  modport source (output valid, valid_res, is_work_day, total_days, work_days,
                  input ready);
  modport sink (input valid, valid_res, is_work_day, total_days, work_days,
                output ready);
endinterface

### rtl/core/wdsc_ctrl.sv
// Controller: sequences load, day numbers, weekday count, holiday sweep, output.
module wdsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wdsc_pkg::wdsc_sts_t sts,
  output wdsc_pkg::wdsc_cmd_t cmd
);
  import wdsc_pkg::*;

  wdsc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DAYS;
      ST_DAYS: state_next = ST_WEEK;
      ST_WEEK: state_next = ST_SUM;
      ST_SUM:  state_next = ST_HOLI;
      ST_HOLI: if (sts.last_year) state_next = ST_DONE;
      ST_DONE: if (sts.out_taken) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DAYS: cmd.calc_days = 1'b1;
      ST_WEEK: cmd.calc_week = 1'b1;
      ST_SUM:  cmd.calc_sum = 1'b1;
      ST_HOLI: cmd.step_year = 1'b1;
      ST_DONE: cmd.out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

### rtl/core/wdsc_dp.sv
// Datapath: date checks, day numbers, weekday count and per-year holiday sweep.
module wdsc_dp #(
  parameter int unsigned MAX_YEAR = 4095
) (
  input  logic                clk,
  input  logic                mode,
  input  logic [11:0]         first_year,
  input  logic [3:0]          first_month,
  input  logic [4:0]          first_day,
  input  logic [11:0]         second_year,
  input  logic [3:0]          second_month,
  input  logic [4:0]          second_day,
  input  wdsc_pkg::wdsc_cmd_t cmd,
  input  logic                out_ready,
  output wdsc_pkg::wdsc_sts_t sts,
  output logic                valid_res,
  output logic                is_work_day,
  output logic [19:0]         total_days,
  output logic [19:0]         work_days
);
  import wdsc_pkg::*;

  logic             r_mode;
  logic [YearW-1:0] y1, y2, ycur;
  logic [3:0]       m1, m2;
  logic [4:0]       d1, d2;
  logic             ok1, ok2;
  logic [DayNumW-1:0] n1, n2, ystart;
  logic [CountW-1:0] wcount;
  logic              rng_ok;
  logic [CountW-1:0] q1, q2;
  logic [2:0]        r1, r2, ydow;
  logic              sweep_on;
  logic              lp_cur;

  // Date validity
  function automatic logic date_ok(input logic [YearW-1:0] y, input logic [3:0] m,
                                   input logic [4:0] d);
    begin
      date_ok = (y >= YearW'(BaseYear)) && (32'(y) <= MAX_YEAR) &&
                (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) &&
                (d <= month_len(m, is_leap(y)));
    end
  endfunction

  // Day number of 1 Jan of year y, counted from 1 Jan 2000
  function automatic logic [DayNumW-1:0] year_base(input logic [YearW-1:0] y);
    logic [YearW-1:0] dy, ym;
    logic [24:0]      p;
    logic [5:0]       q;
    logic [DayNumW-1:0] lp;
    begin
      dy = y - YearW'(BaseYear);
      ym = y - 12'd1;
      p  = scale100(ym);
      q  = p[24:19];
      lp = DayNumW'(ym[YearW-1:2]) - DayNumW'(q) + DayNumW'(q[5:2]) - DayNumW'(484);
      year_base = DayNumW'(dy) * DayNumW'(365) + lp;
    end
  endfunction

  function automatic logic [DayNumW-1:0] day_in(input logic [YearW-1:0] y,
                                                input logic [3:0] m, input logic [4:0] d);
    logic [8:0] ms;
    begin
      ms = month_start(m);
      if (m > 4'd2 && is_leap(y)) ms = ms + 9'd1;
      day_in = DayNumW'(ms) + DayNumW'(d) - DayNumW'(1);
    end
  endfunction

  // Weekdays among day numbers below 7*q+r
  function automatic logic [CountW-1:0] wk_from(input logic [CountW-1:0] q,
                                                input logic [2:0] r);
    begin
      wk_from = (q << 2) + q + ((r > 3'd2) ? CountW'(r - 3'd2) : '0);
    end
  endfunction

  assign lp_cur = is_leap(ycur);

  // Holidays of the current sweep year that fall on weekdays in range
  logic [DayNumW-1:0] hday [11];
  logic [3:0]         hsum [11];
  logic [10:0]        hit;
  logic [3:0]         nhit;
  always_comb begin
    nhit = '0;
    for (int i = 0; i < 11; i++) begin
      hday[i] = ystart + DayNumW'(holiday_doy(4'(i), lp_cur));
      hsum[i] = 4'(ydow) + 4'(holiday_dow(4'(i), lp_cur));
      hit[i]  = (hday[i] >= n1) && (hday[i] <= n2) &&
                (((hsum[i] >= 4'd7) ? (hsum[i] - 4'd7) : hsum[i]) >= 4'd2);
      nhit    = nhit + 4'(hit[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_mode <= mode;
      y1 <= first_year;  m1 <= first_month;  d1 <= first_day;
      y2 <= second_year; m2 <= second_month; d2 <= second_day;
      ycur <= first_year;
    end
    // Check dates and form day numbers
    if (cmd.calc_days) begin
      ok1    <= date_ok(y1, m1, d1);
      ok2    <= date_ok(y2, m2, d2);
      n1     <= year_base(y1) + day_in(y1, m1, d1);
      n2     <= year_base(y2) + day_in(y2, m2, d2);
      ystart <= year_base(y1);
    end
    // Split day numbers into weeks and weekday slots, set result flags
    if (cmd.calc_week) begin
      rng_ok      <= r_mode ? (ok1 && ok2 && (n2 >= n1)) : ok1;
      is_work_day <= !r_mode && ok1 && (mod7(n1) >= 3'd2) && !is_holiday(m1, d1);
      sweep_on    <= r_mode && ok1 && ok2 && (n2 >= n1);
      q1          <= div7(n1);
      r1          <= mod7(n1);
      q2          <= div7(n2 + DayNumW'(1));
      r2          <= mod7(n2 + DayNumW'(1));
      ydow        <= mod7(ystart);
    end
    // Weekday count over the range
    if (cmd.calc_sum) wcount <= wk_from(q2, r2) - wk_from(q1, r1);
    // Step one year through the range, dropping holiday weekdays
    if (cmd.step_year && sweep_on) begin
      wcount <= wcount - CountW'(nhit);
      ystart <= ystart + (lp_cur ? DayNumW'(366) : DayNumW'(365));
      ycur   <= ycur + 12'd1;
      ydow   <= lp_cur ? ((ydow >= 3'd5) ? ydow - 3'd5 : ydow + 3'd2)
                       : ((ydow == 3'd6) ? 3'd0 : ydow + 3'd1);
    end
  end

  assign sts.last_year = !sweep_on || !(ycur < y2);
  assign sts.out_taken = out_ready;

  assign valid_res  = rng_ok;
  assign total_days = (r_mode && rng_ok) ? CountW'(n2 - n1 + DayNumW'(1)) : '0;
  assign work_days  = (r_mode && rng_ok) ? wcount : '0;
endmodule

### rtl/core/workday_and_span_counter_unit.sv
// Workday and span counter: one calendar request in, one result out.
// Request channel (req): mode 0 asks whether first date is a working day;
// mode 1 counts total and working days over first..second inclusive.
// Result channel (res): valid_res, is_work_day, total_days, work_days.
// A taken request passes through the day-number, weekday-count and sum
// states, then the holiday sweep, after which res.valid rises; the sweep
// steps one year per cycle through a single holiday comparator bank up to
// the last year of a valid range. Invalid or single-date requests skip the sweep.
// One request is worked at a time; req.ready is high only when idle, the
// cycle after the result leaves, so a new request waits for the last result.
// The result holds on res until res.ready is seen; no request is taken
// meanwhile. Synchronous reset returns to idle and drops any pending result.
// Years 2000..MAX_YEAR are valid; others give valid_res = 0 and zero counts.
module workday_and_span_counter_unit #(
  parameter int unsigned MAX_YEAR = 4095
) (
  input logic       clk,
  input logic       rst,
  wdsc_req_if.sink  req,
  wdsc_res_if.source res
);
  import wdsc_pkg::*;

  wdsc_cmd_t cmd;
  wdsc_sts_t sts;

  wdsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .sts(sts), .cmd(cmd)
  );

  wdsc_dp #(.MAX_YEAR(MAX_YEAR)) u_dp (
    .clk(clk), .mode(req.mode),
    .first_year(req.first_year), .first_month(req.first_month),
    .first_day(req.first_day), .second_year(req.second_year),
    .second_month(req.second_month), .second_day(req.second_day),
    .cmd(cmd), .out_ready(res.ready), .sts(sts),
    .valid_res(res.valid_res), .is_work_day(res.is_work_day),
    .total_days(res.total_days), .work_days(res.work_days)
  );

  assign res.valid = cmd.out_valid;
endmodule

### rtl/core/wdsc_chk.sv
// Checker: port-level properties of the workday counter, bound to the top level.
module wdsc_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        valid_res,
  input logic        is_work_day,
  input logic [19:0] total_days,
  input logic [19:0] work_days
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(total_days))
    else $error("result dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> total_days == 20'd0 && work_days == 20'd0 && !is_work_day)
    else $error("invalid result not zero");
  a_le: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> work_days <= total_days) else $error("work days exceed total");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready) else $error("took two items");
endmodule

bind workday_and_span_counter_unit wdsc_chk u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .valid_res(res.valid_res),
  .is_work_day(res.is_work_day), .total_days(res.total_days),
  .work_days(res.work_days)
);

### verif/tb_workday_and_span_counter_unit.sv
// Testbench: calendar queries and day-span counts against an in-bench calendar predictor.
`timescale 1ns / 100ps

module tb_workday_and_span_counter_unit;

  localparam int unsigned MaxYear = 4095;
  localparam int unsigned WatchLimit = 40000;

  typedef struct packed {
    logic        mode;
    logic [11:0] y1;
    logic [3:0]  m1;
    logic [4:0]  d1;
    logic [11:0] y2;
    logic [3:0]  m2;
    logic [4:0]  d2;
  } query_t;

  typedef struct packed {
    logic        ok;
    logic        work;
    logic [19:0] total;
    logic [19:0] wcount;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wdsc_req_if req ();
  wdsc_res_if res ();

  workday_and_span_counter_unit #(.MAX_YEAR(MaxYear)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .res(res.source)
  );

  always #5 clk = ~clk;

  answer_t pending_answers[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      idle_cycles = 0;

  // Calendar arithmetic, written from scratch at integer width.
  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && leap_year(y)) return 29;
    return lens[m - 1];
  endfunction

  function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
    if (y < 2000 || y > MaxYear || m < 1 || m > 12) return 0;
    return d >= 1 && d <= month_days(y, m);
  endfunction

  function automatic int unsigned leaps_through(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Day index from 1 Jan 2000 (a Saturday).
  function automatic int unsigned day_index(int unsigned y, int unsigned m, int unsigned d);
    int unsigned starts[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned n;
    n = 365 * (y - 2000) + leaps_through(y - 1) - leaps_through(1999) + starts[m - 1];
    if (m > 2 && leap_year(y)) n++;
    return n + d - 1;
  endfunction

  function automatic bit mon_to_fri(int unsigned n);
    return (n % 7) >= 2;
  endfunction

  function automatic int unsigned mon_to_fri_below(int unsigned n);
    int unsigned r;
    r = n % 7;
    return (n / 7) * 5 + (r > 2 ? r - 2 : 0);
  endfunction

  function automatic answer_t predict_answer(query_t q);
    int unsigned hm[11] = '{1, 5, 5, 7, 7, 9, 10, 11, 12, 12, 12};
    int unsigned hd[11] = '{1, 1, 8, 5, 6, 28, 28, 17, 24, 25, 26};
    answer_t a;
    int unsigned n1, n2, h, cnt;
    bit hol;
    a = '0;
    if (q.mode == 1'b0) begin
      if (date_valid(q.y1, q.m1, q.d1)) begin
        a.ok = 1'b1;
        hol = 0;
        for (int i = 0; i < 11; i++)
          if (hm[i] == q.m1 && hd[i] == q.d1) hol = 1;
        a.work = mon_to_fri(day_index(q.y1, q.m1, q.d1)) && !hol;
      end
    end else if (date_valid(q.y1, q.m1, q.d1) && date_valid(q.y2, q.m2, q.d2)) begin
      n1 = day_index(q.y1, q.m1, q.d1);
      n2 = day_index(q.y2, q.m2, q.d2);
      if (n2 >= n1) begin
        a.ok = 1'b1;
        a.total = 20'(n2 - n1 + 1);
        cnt = mon_to_fri_below(n2 + 1) - mon_to_fri_below(n1);
        for (int unsigned y = q.y1; y <= q.y2; y++)
          for (int i = 0; i < 11; i++) begin
            h = day_index(y, hm[i], hd[i]);
            if (h >= n1 && h <= n2 && mon_to_fri(h)) cnt--;
          end
        a.wcount = 20'(cnt);
      end
    end
    return a;
  endfunction

  // Send one query; prediction is queued at acceptance.
  task automatic send_query(query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    {req.mode, req.first_year, req.first_month, req.first_day,
     req.second_year, req.second_month, req.second_day} <= q;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_answers.push_back(predict_answer(q));
    @(negedge clk);
  endtask

  // Drop the request and hold until every expected result has come.
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  function automatic query_t make_query(bit m, int y1, int m1, int d1, int y2, int m2, int d2);
    return {m, 12'(y1), 4'(m1), 5'(d1), 12'(y2), 4'(m2), 5'(d2)};
  endfunction

  // Mostly valid dates, short spans, some noise and an occasional long span.
  function automatic query_t random_query();
    query_t q;
    int unsigned y, m, span;
    q = 43'({$urandom, $urandom});
    q.mode = 1'($urandom_range(1));
    if ($urandom_range(9) < 8) begin
      y = ($urandom_range(9) == 0) ? $urandom_range(MaxYear, 2000) : $urandom_range(2060, 2000);
      m = $urandom_range(12, 1);
      q.y1 = 12'(y); q.m1 = 4'(m); q.d1 = 5'($urandom_range(month_days(y, m), 1));
      span = ($urandom_range(19) == 0) ? $urandom_range(MaxYear - y) : $urandom_range(3);
      if ($urandom_range(9) == 0 && y > 2000) y = y - 1; else y = y + span;
      m = $urandom_range(12, 1);
      q.y2 = 12'(y); q.m2 = 4'(m); q.d2 = 5'($urandom_range(month_days(y, m), 1));
    end
    return q;
  endfunction

  task automatic test_directed();
    send_query(make_query(0, 2000, 1, 1, 0, 0, 0));
    send_query(make_query(0, 2000, 1, 3, 4095, 15, 31));
    send_query(make_query(0, 2000, 2, 29, 0, 0, 0));
    send_query(make_query(0, 1900, 2, 29, 0, 0, 0));
    send_query(make_query(0, 2100, 2, 29, 0, 0, 0));
    send_query(make_query(0, 1999, 12, 31, 0, 0, 0));
    send_query(make_query(0, 4095, 12, 31, 0, 0, 0));
    send_query(make_query(0, 2023, 0, 5, 0, 0, 0));
    send_query(make_query(0, 2023, 13, 5, 0, 0, 0));
    send_query(make_query(0, 2023, 4, 31, 0, 0, 0));
    send_query(make_query(0, 2023, 4, 0, 0, 0, 0));
    send_query(make_query(0, 2024, 12, 24, 0, 0, 0));
    send_query(make_query(0, 2024, 7, 5, 0, 0, 0));
    send_query(make_query(1, 2000, 1, 1, 2000, 12, 31));
    send_query(make_query(1, 2024, 3, 1, 2024, 3, 1));
    send_query(make_query(1, 2024, 3, 2, 2024, 3, 1));
    send_query(make_query(1, 2025, 1, 1, 2024, 12, 31));
    send_query(make_query(1, 2024, 2, 30, 2025, 1, 1));
    send_query(make_query(1, 2024, 1, 1, 2025, 15, 31));
    send_query(make_query(1, 2000, 1, 1, 4095, 12, 31));
    send_query(make_query(1, 2023, 12, 20, 2024, 1, 5));
    send_query(make_query(1, 4095, 12, 31, 4095, 12, 31));
    send_query(make_query(1, 0, 0, 0, 0, 0, 0));
    send_query(make_query(1, 4095, 15, 31, 4095, 15, 31));
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_query(random_query());
  endtask

  task automatic test_pause_until_drained();
    send_query(random_query());
    wait_drained();
    send_query(make_query(1, 2001, 5, 1, 2003, 5, 8));
  endtask

  // Drive the result-side ready at random.
  always @(negedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst && res.valid && res.ready) begin
      got = {res.valid_res, res.is_work_day, res.total_days, res.work_days};
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.ok !== want.ok) begin
          $display("%0t: valid_res expected %0d got %0d", $time, want.ok, got.ok);
          errors++;
        end
        if (got.work !== want.work) begin
          $display("%0t: is_work_day expected %0d got %0d", $time, want.work, got.work);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: total_days expected %0d got %0d", $time, want.total, got.total);
          errors++;
        end
        if (got.wcount !== want.wcount) begin
          $display("%0t: work_days expected %0d got %0d", $time, want.wcount, got.wcount);
          errors++;
        end
      end
    end
  end

  // End the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    {req.mode, req.first_year, req.first_month, req.first_day,
     req.second_year, req.second_month, req.second_day} = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(65, 0, 0);
    test_random(65, 55, 0);
    test_random(65, 0, 55);
    test_pause_until_drained();
    test_random(65, 34, 34);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
